@@ hdl/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg
// Shared constants, codes and types of the multi-source shortest path block.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned NUM_NODES  = 1024;
  localparam int unsigned NUM_EDGES  = 8192;
  localparam int unsigned NODE_W     = 10;
  localparam int unsigned EIDX_W     = 13;
  localparam int unsigned EPTR_W     = 14;
  localparam int unsigned WGT_W      = 16;
  localparam int unsigned DIST_W     = 31;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_EDGE   = 3'd1;
  localparam logic [OP_W-1:0] OP_SOURCE = 3'd2;
  localparam logic [OP_W-1:0] OP_SOLVE  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  localparam logic [EPTR_W-1:0] EDGE_NULL    = EPTR_W'(NUM_EDGES);
  localparam logic [EPTR_W-1:0] EDGE_LAST_OK = EPTR_W'(NUM_EDGES - 2);
  localparam logic [DIST_W-1:0] DIST_UNREACH = 31'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_SAT     = 31'h7FFF_FFFE;
  localparam logic [NODE_W-1:0] NODE_LAST    = NODE_W'(NUM_NODES - 1);
  localparam logic [NODE_W:0]   QUEUE_FULL   = (NODE_W+1)'(NUM_NODES);

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_ADD,
    CMD_SOLVE,
    CMD_QUERY
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [WGT_W-1:0]  w;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic sweeping;
  } eng_status_t;

endpackage

@@ hdl/msp_if.sv @@
// ----------------------------------------------------------------------------
// msp_in_if / msp_out_if
// Valid/ready channels carrying input transactions and query results.
// ----------------------------------------------------------------------------
interface msp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [9:0]  node_a;
  logic [9:0]  node_b;
  logic [15:0] weight;

  modport source (output valid, operation, node_a, node_b, weight, input ready);
  modport sink (input valid, operation, node_a, node_b, weight, output ready);
endinterface

interface msp_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] distance;
  logic        reachable;
  logic        edges_overflowed;

  modport source (output valid, distance, reachable, edges_overflowed, input ready);
  modport sink (input valid, distance, reachable, edges_overflowed, output ready);
endinterface

@@ hdl/multi_source_shortest_path.sv @@
// ----------------------------------------------------------------------------
// multi_source_shortest_path
// Loads an undirected weighted graph, runs a queue-based Bellman-Ford walk
// from the super-source node 0 and answers distance queries.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its node tables and takes
// no command from its queue until it ends. Add edge and add source link the
// edge into the lists of both end nodes in turn, a query waits out any output
// stall, and clear runs a pass over the head table. Solve runs a pass over the
// distance table, then takes nodes from the work queue one by one and walks
// the edges of each. A 4-entry command queue lets transactions be taken while
// the engine is busy.
module multi_source_shortest_path import msp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i,
  msp_in_if.sink            in_if,
  msp_out_if.source         out_if
);

  logic [NODE_W-1:0] node_count_q;
  cmd_t              cmd;
  logic              cmd_valid, cmd_ready;
  eng_status_t       sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_LAST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  msp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  msp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .top_i       (node_count_q),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_if      (out_if),
    .status_o    (sts)
  );

  a_sweep_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.sweeping |-> !cmd_ready)
    else $error("engine took a command during a clearing pass");

  a_unreached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.reachable) |-> (out_if.distance == '0))
    else $error("unreachable result with nonzero distance");

  a_reached_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.reachable) |-> (out_if.distance != DIST_UNREACH))
    else $error("reachable result carries unreached marker");

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> !cmd_ready)
    else $error("engine ready while busy");

endmodule

@@ hdl/msp_front.sv @@
// ----------------------------------------------------------------------------
// msp_front
// Accepts input transactions, decodes them into engine commands and buffers
// them in a short queue.
// ----------------------------------------------------------------------------
module msp_front import msp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  msp_in_if.sink      in_if,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i
);

  cmd_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  cmd_t               dec;
  logic               dec_ok;
  logic               push, pop;

  always_comb begin
    dec    = '{op: CMD_CLEAR, a: in_if.node_a, b: in_if.node_b, w: in_if.weight};
    dec_ok = 1'b1;
    unique case (in_if.operation)
      OP_CLEAR: dec.op = CMD_CLEAR;
      OP_EDGE:  dec.op = CMD_ADD;
      OP_SOURCE: begin
        dec.op = CMD_ADD;
        dec.a  = '0;
        dec.b  = in_if.node_a;
        dec.w  = '0;
      end
      OP_SOLVE: dec.op = CMD_SOLVE;
      OP_QUERY: dec.op = CMD_QUERY;
      default:  dec_ok = 1'b0;
    endcase
  end

  assign in_if.ready = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign push        = in_if.valid && in_if.ready && dec_ok;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hdl/msp_engine.sv @@
// ----------------------------------------------------------------------------
// msp_engine
// Executes commands on the graph memories: list clearing, edge linking,
// the queue-driven relaxation walk and distance lookup.
// ----------------------------------------------------------------------------
module msp_engine import msp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NODE_W-1:0] top_i,
  input  cmd_t              cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  msp_out_if.source         out_if,
  output eng_status_t       status_o
);

  localparam logic [3:0] S_SWEEP  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ADD_WA = 4'd2;
  localparam logic [3:0] S_ADD_RB = 4'd3;
  localparam logic [3:0] S_ADD_WB = 4'd4;
  localparam logic [3:0] S_QRES   = 4'd5;
  localparam logic [3:0] S_SINIT  = 4'd6;
  localparam logic [3:0] S_POP    = 4'd7;
  localparam logic [3:0] S_POP2   = 4'd8;
  localparam logic [3:0] S_HEAD   = 4'd9;
  localparam logic [3:0] S_EDGE   = 4'd10;
  localparam logic [3:0] S_EDGE2  = 4'd11;
  localparam logic [3:0] S_RELAX  = 4'd12;

  logic [EPTR_W-1:0] head_mem [NUM_NODES];
  logic [DIST_W-1:0] best_mem [NUM_NODES];
  logic              inq_mem  [NUM_NODES];
  logic [NODE_W-1:0] wq_mem   [NUM_NODES];
  logic [NODE_W-1:0] etgt_mem [NUM_EDGES];
  logic [WGT_W-1:0]  ewgt_mem [NUM_EDGES];
  logic [EPTR_W-1:0] enxt_mem [NUM_EDGES];

  logic [EPTR_W-1:0] head_rd;
  logic [DIST_W-1:0] best_rd;
  logic              inq_rd;
  logic [NODE_W-1:0] wq_rd;
  logic [NODE_W-1:0] etgt_rd;
  logic [WGT_W-1:0]  ewgt_rd;
  logic [EPTR_W-1:0] enxt_rd;

  logic              head_we, head_re, best_we, best_re, inq_we, inq_re;
  logic              wq_we, wq_re, edge_we, edge_re;
  logic [NODE_W-1:0] head_wa, head_ra, best_wa, best_ra, inq_wa, inq_ra, wq_wa, wq_ra;
  logic [EPTR_W-1:0] head_wd;
  logic [DIST_W-1:0] best_wd;
  logic              inq_wd;
  logic [NODE_W-1:0] wq_wd, etgt_wd;
  logic [EIDX_W-1:0] edge_wa, edge_ra;
  logic [EPTR_W-1:0] enxt_wd;

  logic [3:0]        state_q, state_d;
  logic [NODE_W-1:0] sweep_q, sweep_d;
  logic              sw_head_q, sw_head_d, sw_dist_q, sw_dist_d;
  logic [EPTR_W-1:0] used_q, used_d;
  logic              ovf_q, ovf_d;
  logic [NODE_W-1:0] a_q, a_d, b_q, b_d;
  logic [WGT_W-1:0]  w_q, w_d;
  logic              qok_q, qok_d;
  logic [NODE_W-1:0] qrd_q, qrd_d, qwr_q, qwr_d;
  logic [NODE_W:0]   qcnt_q, qcnt_d;
  logic [EPTR_W-1:0] e_q, e_d;
  logic [DIST_W-1:0] dt_q, dt_d;
  logic              ov_q, ov_d;
  logic [DIST_W-1:0] od_q, od_d;
  logic              orch_q, orch_d, oovf_q, oovf_d;
  logic [DIST_W:0]   cand_sum;
  logic [DIST_W-1:0] cand;
  logic              take;

  assign cmd_ready_o       = (state_q == S_IDLE);
  assign take              = cmd_valid_i && cmd_ready_o;
  assign status_o.busy     = (state_q != S_IDLE);
  assign status_o.sweeping = (state_q == S_SWEEP);

  assign out_if.valid            = ov_q;
  assign out_if.distance         = od_q;
  assign out_if.reachable        = orch_q;
  assign out_if.edges_overflowed = oovf_q;

  assign cand_sum = {1'b0, dt_q} + (DIST_W+1)'(ewgt_rd);
  assign cand     = (cand_sum >= {1'b0, DIST_UNREACH}) ? DIST_SAT : cand_sum[DIST_W-1:0];

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    sw_head_d = sw_head_q;
    sw_dist_d = sw_dist_q;
    used_d    = used_q;
    ovf_d     = ovf_q;
    a_d       = a_q;
    b_d       = b_q;
    w_d       = w_q;
    qok_d     = qok_q;
    qrd_d     = qrd_q;
    qwr_d     = qwr_q;
    qcnt_d    = qcnt_q;
    e_d       = e_q;
    dt_d      = dt_q;
    ov_d      = ov_q && !out_if.ready;
    od_d      = od_q;
    orch_d    = orch_q;
    oovf_d    = oovf_q;

    head_we = 1'b0; head_wa = '0; head_wd = EDGE_NULL; head_re = 1'b0; head_ra = '0;
    best_we = 1'b0; best_wa = '0; best_wd = DIST_UNREACH; best_re = 1'b0; best_ra = '0;
    inq_we  = 1'b0; inq_wa  = '0; inq_wd  = 1'b0; inq_re = 1'b0; inq_ra = '0;
    wq_we   = 1'b0; wq_wa   = '0; wq_wd   = '0; wq_re = 1'b0; wq_ra = '0;
    edge_we = 1'b0; edge_wa = used_q[EIDX_W-1:0]; etgt_wd = '0; enxt_wd = head_rd;
    edge_re = 1'b0; edge_ra = e_q[EIDX_W-1:0];

    unique case (state_q)
      S_SWEEP: begin
        head_we = sw_head_q;
        head_wa = sweep_q;
        best_we = sw_dist_q;
        best_wa = sweep_q;
        inq_we  = sw_dist_q;
        inq_wa  = sweep_q;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == NODE_LAST) begin
          state_d = sw_dist_q && !sw_head_q ? S_SINIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          a_d = cmd_i.a;
          b_d = cmd_i.b;
          w_d = cmd_i.w;
          unique case (cmd_i.op)
            CMD_CLEAR: begin
              used_d    = '0;
              ovf_d     = 1'b0;
              sweep_d   = '0;
              sw_head_d = 1'b1;
              sw_dist_d = 1'b0;
              state_d   = S_SWEEP;
            end
            CMD_ADD: begin
              if (used_q > EDGE_LAST_OK) begin
                ovf_d = 1'b1;
              end else begin
                head_re = 1'b1;
                head_ra = cmd_i.a;
                state_d = S_ADD_WA;
              end
            end
            CMD_SOLVE: begin
              sweep_d   = '0;
              sw_head_d = 1'b0;
              sw_dist_d = 1'b1;
              state_d   = S_SWEEP;
            end
            CMD_QUERY: begin
              qok_d   = (cmd_i.a <= top_i);
              best_re = 1'b1;
              best_ra = cmd_i.a;
              state_d = S_QRES;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_WA: begin
        edge_we = 1'b1;
        etgt_wd = b_q;
        head_we = 1'b1;
        head_wa = a_q;
        head_wd = used_q;
        used_d  = used_q + 1'b1;
        state_d = S_ADD_RB;
      end
      S_ADD_RB: begin
        head_re = 1'b1;
        head_ra = b_q;
        state_d = S_ADD_WB;
      end
      S_ADD_WB: begin
        edge_we = 1'b1;
        etgt_wd = a_q;
        head_we = 1'b1;
        head_wa = b_q;
        head_wd = used_q;
        used_d  = used_q + 1'b1;
        state_d = S_IDLE;
      end
      S_QRES: begin
        if (!ov_q || out_if.ready) begin
          ov_d    = 1'b1;
          orch_d  = qok_q && (best_rd != DIST_UNREACH);
          od_d    = (qok_q && (best_rd != DIST_UNREACH)) ? best_rd : '0;
          oovf_d  = ovf_q;
          state_d = S_IDLE;
        end
      end
      S_SINIT: begin
        best_we = 1'b1;
        best_wd = '0;
        inq_we  = 1'b1;
        inq_wd  = 1'b1;
        wq_we   = 1'b1;
        qrd_d   = '0;
        qwr_d   = NODE_W'(1);
        qcnt_d  = (NODE_W+1)'(1);
        state_d = S_POP;
      end
      S_POP: begin
        if (qcnt_q == '0) begin
          state_d = S_IDLE;
        end else begin
          wq_re   = 1'b1;
          wq_ra   = qrd_q;
          qrd_d   = qrd_q + 1'b1;
          qcnt_d  = qcnt_q - 1'b1;
          state_d = S_POP2;
        end
      end
      S_POP2: begin
        inq_we  = 1'b1;
        inq_wa  = wq_rd;
        head_re = 1'b1;
        head_ra = wq_rd;
        best_re = 1'b1;
        best_ra = wq_rd;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        e_d     = head_rd;
        dt_d    = best_rd;
        state_d = S_EDGE;
      end
      S_EDGE: begin
        if (e_q[EPTR_W-1]) begin
          state_d = S_POP;
        end else begin
          edge_re = 1'b1;
          state_d = S_EDGE2;
        end
      end
      S_EDGE2: begin
        if (etgt_rd <= top_i) begin
          best_re = 1'b1;
          best_ra = etgt_rd;
          inq_re  = 1'b1;
          inq_ra  = etgt_rd;
          state_d = S_RELAX;
        end else begin
          e_d     = enxt_rd;
          state_d = S_EDGE;
        end
      end
      S_RELAX: begin
        if (cand < best_rd) begin
          best_we = 1'b1;
          best_wa = etgt_rd;
          best_wd = cand;
          if (!inq_rd && qcnt_q < QUEUE_FULL) begin
            wq_we  = 1'b1;
            wq_wa  = qwr_q;
            wq_wd  = etgt_rd;
            qwr_d  = qwr_q + 1'b1;
            qcnt_d = qcnt_q + 1'b1;
            inq_we = 1'b1;
            inq_wa = etgt_rd;
            inq_wd = 1'b1;
          end
        end
        e_d     = enxt_rd;
        state_d = S_EDGE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[head_ra];
    if (best_we) best_mem[best_wa] <= best_wd;
    if (best_re) best_rd <= best_mem[best_ra];
    if (inq_we) inq_mem[inq_wa] <= inq_wd;
    if (inq_re) inq_rd <= inq_mem[inq_ra];
    if (wq_we) wq_mem[wq_wa] <= wq_wd;
    if (wq_re) wq_rd <= wq_mem[wq_ra];
    if (edge_we) begin
      etgt_mem[edge_wa] <= etgt_wd;
      ewgt_mem[edge_wa] <= w_q;
      enxt_mem[edge_wa] <= enxt_wd;
    end
    if (edge_re) begin
      etgt_rd <= etgt_mem[edge_ra];
      ewgt_rd <= ewgt_mem[edge_ra];
      enxt_rd <= enxt_mem[edge_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    w_q   <= w_d;
    qok_q <= qok_d;
    e_q   <= e_d;
    dt_q  <= dt_d;
    od_q  <= od_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      sweep_q   <= '0;
      sw_head_q <= 1'b1;
      sw_dist_q <= 1'b1;
      used_q    <= '0;
      ovf_q     <= 1'b0;
      qrd_q     <= '0;
      qwr_q     <= '0;
      qcnt_q    <= '0;
      ov_q      <= 1'b0;
      orch_q    <= 1'b0;
      oovf_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      sw_head_q <= sw_head_d;
      sw_dist_q <= sw_dist_d;
      used_q    <= used_d;
      ovf_q     <= ovf_d;
      qrd_q     <= qrd_d;
      qwr_q     <= qwr_d;
      qcnt_q    <= qcnt_d;
      ov_q      <= ov_d;
      orch_q    <= orch_d;
      oovf_q    <= oovf_d;
    end
  end

endmodule

@@ verif/multi_source_shortest_path_tb.sv @@
// ----------------------------------------------------------------------------
// multi_source_shortest_path_tb
// Checks the multi-source shortest path block against a behavioral model.
// Transactions are queued by a stimulus process, sent by a clocked driver
// and predicted on acceptance; a clocked monitor compares query results.
// ----------------------------------------------------------------------------
module multi_source_shortest_path_tb;
  import msp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_SPARE = 3'd5;
  localparam int unsigned UNREACHED   = 32'h7FFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE      = 20_000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [WGT_W-1:0]  w;
  } txn_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              overflowed;
  } answer_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [NODE_W-1:0] cfg_wdata_i;

  msp_in_if  in_if ();
  msp_out_if out_if ();

  multi_source_shortest_path u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // graph model
  int unsigned edge_to [NUM_EDGES];
  int unsigned edge_wt [NUM_EDGES];
  int unsigned edge_nx [NUM_EDGES];
  int unsigned head_of [NUM_NODES];
  int unsigned dist_of [NUM_NODES];
  int unsigned edges_stored;
  bit          dropped;
  int unsigned top_node;

  txn_t        pending[$];
  answer_t     answers_due[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_queries;
  int unsigned n_solves;
  int unsigned n_txns;
  bit          idle_on;
  bit          hold_req;
  int unsigned gap;
  int unsigned stall;
  int unsigned hold_left;
  bit          hold_done;

  task automatic link_pair(int unsigned a, int unsigned b, int unsigned w);
    if (edges_stored + 2 > NUM_EDGES) begin
      dropped = 1'b1;
    end else begin
      edge_to[edges_stored] = b;
      edge_wt[edges_stored] = w;
      edge_nx[edges_stored] = head_of[a];
      head_of[a] = edges_stored;
      edge_to[edges_stored+1] = a;
      edge_wt[edges_stored+1] = w;
      edge_nx[edges_stored+1] = head_of[b];
      head_of[b] = edges_stored + 1;
      edges_stored += 2;
    end
  endtask

  task automatic relax_all();
    int unsigned work[$];
    bit          queued[NUM_NODES];
    int unsigned t;
    int unsigned e;
    int unsigned v;
    longint unsigned cand;
    foreach (dist_of[i]) begin
      dist_of[i] = UNREACHED;
      queued[i] = 1'b0;
    end
    dist_of[0] = 0;
    work.push_back(0);
    queued[0] = 1'b1;
    while (work.size() > 0) begin
      t = work.pop_front();
      queued[t] = 1'b0;
      e = head_of[t];
      while (e < NUM_EDGES) begin
        v = edge_to[e];
        if (v <= top_node) begin
          cand = longint'(dist_of[t]) + edge_wt[e];
          if (cand >= UNREACHED) cand = UNREACHED - 1;
          if (cand < dist_of[v]) begin
            dist_of[v] = 32'(cand);
            if (!queued[v] && work.size() < NUM_NODES) begin
              work.push_back(v);
              queued[v] = 1'b1;
            end
          end
        end
        e = edge_nx[e];
      end
    end
  endtask

  task automatic apply_txn(txn_t t);
    answer_t r;
    n_txns++;
    case (t.op)
      OP_CLEAR: begin
        foreach (head_of[i]) head_of[i] = NUM_EDGES;
        edges_stored = 0;
        dropped = 1'b0;
      end
      OP_EDGE:   link_pair(t.a, t.b, t.w);
      OP_SOURCE: link_pair(0, t.a, 0);
      OP_SOLVE: begin
        n_solves++;
        relax_all();
      end
      OP_QUERY: begin
        r = '0;
        if (t.a <= top_node && dist_of[t.a] != UNREACHED) begin
          r.reachable = 1'b1;
          r.distance = dist_of[t.a][DIST_W-1:0];
        end
        r.overflowed = dropped;
        answers_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_source_shortest_path_tb: errors");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.operation <= '0;
      in_if.node_a    <= '0;
      in_if.node_b    <= '0;
      in_if.weight    <= '0;
      gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_txn(pending.pop_front());
        gap = idle_on ? $urandom_range(0, 7) : 0;
      end else if (!in_if.valid && gap > 0) begin
        gap--;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap == 0 && pending.size() > 0) begin
          in_if.valid     <= 1'b1;
          in_if.operation <= pending[0].op;
          in_if.node_a    <= pending[0].a;
          in_if.node_b    <= pending[0].b;
          in_if.weight    <= pending[0].w;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result sink and monitor
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_queries++;
        if (answers_due.size() == 0) begin
          $error("unexpected result: distance %0d", out_if.distance);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (out_if.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_if.distance);
            errors++;
          end
          if (out_if.reachable !== want.reachable) begin
            $error("reachable: expected %0d, got %0d", want.reachable, out_if.reachable);
            errors++;
          end
          if (out_if.edges_overflowed !== want.overflowed) begin
            $error("edges_overflowed: expected %0d, got %0d", want.overflowed,
                   out_if.edges_overflowed);
            errors++;
          end
        end
        stall = idle_on ? $urandom_range(0, 7) : 0;
      end else if (stall > 0) begin
        stall--;
      end
      if (hold_req && !hold_done && hold_left == 0 && out_if.valid) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      out_if.ready <= (hold_left == 0) && (stall == 0);
    end
  end

  task automatic write_node_count(logic [NODE_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    top_node = 32'(v);
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !in_if.valid && answers_due.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic txn_t mk(logic [OP_W-1:0] op, int unsigned a, int unsigned b,
                              int unsigned w);
    txn_t t;
    t.op = op;
    t.a = NODE_W'(a);
    t.b = NODE_W'(b);
    t.w = WGT_W'(w);
    return t;
  endfunction

  function automatic int unsigned pick_node(int unsigned lim);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_NODES - 1)
                                       : $urandom_range(0, lim);
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned lim;
    int unsigned sent;
    int unsigned k;
    lim = (top_node + 3 > NUM_NODES - 1) ? NUM_NODES - 1 : top_node + 3;
    if (lim > 40 && $urandom_range(0, 1)) lim = 40;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) != 0) pending.push_back(mk(OP_CLEAR, 0, 0, 0));
      k = $urandom_range(1, 12);
      repeat (k) pending.push_back(mk(OP_EDGE, pick_node(lim), pick_node(lim),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                  : $urandom_range(0, 300)));
      repeat ($urandom_range(1, 3)) pending.push_back(mk(OP_SOURCE, pick_node(lim), 0, 0));
      pending.push_back(mk(OP_SOLVE, 0, 0, 0));
      repeat ($urandom_range(2, 8)) pending.push_back(mk(OP_QUERY, pick_node(lim), 0, 0));
      if ($urandom_range(0, 3) == 0)
        pending.push_back(mk(OP_W'($urandom_range(0, 7)), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 65535)));
      if ($urandom_range(0, 4) == 0)
        pending.push_back(mk(OP_W'(OP_SPARE + $urandom_range(0, 2)), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 65535)));
      sent += k + 8;
      wait (pending.size() < 8);
    end
  endtask

  initial begin
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    idle_on     = 1'b0;
    hold_req    = 1'b0;
    errors = 0;
    cycles = 0;
    n_queries = 0;
    n_solves = 0;
    n_txns = 0;
    top_node = NODE_LAST;
    edges_stored = 0;
    dropped = 1'b0;
    foreach (head_of[i]) head_of[i] = NUM_EDGES;
    foreach (dist_of[i]) dist_of[i] = UNREACHED;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_node_count(NODE_LAST);
    pending.push_back(mk(OP_QUERY, 5, 0, 0));
    pending.push_back(mk(OP_SOURCE, 5, 0, 0));
    pending.push_back(mk(OP_EDGE, 5, 1023, 65535));
    pending.push_back(mk(OP_EDGE, 5, 7, 0));
    pending.push_back(mk(OP_EDGE, 7, 8, 1));
    pending.push_back(mk(OP_EDGE, 1023, 1023, 1));
    pending.push_back(mk(OP_SOLVE, 0, 0, 0));
    pending.push_back(mk(OP_QUERY, 0, 0, 0));
    pending.push_back(mk(OP_QUERY, 1023, 0, 0));
    pending.push_back(mk(OP_QUERY, 8, 0, 0));
    pending.push_back(mk(OP_QUERY, 9, 0, 0));
    pending.push_back(mk(OP_SPARE, 1023, 1023, 65535));
    pending.push_back(mk(OP_W'(OP_SPARE + 2), 0, 0, 0));
    pending.push_back(mk(OP_CLEAR, 0, 0, 0));
    pending.push_back(mk(OP_QUERY, 1023, 0, 0));
    pending.push_back(mk(OP_SOLVE, 0, 0, 0));
    pending.push_back(mk(OP_QUERY, 5, 0, 0));
    pending.push_back(mk(OP_QUERY, 0, 0, 0));
    drain();

    write_node_count(1);
    pending.push_back(mk(OP_SOURCE, 1, 0, 0));
    pending.push_back(mk(OP_EDGE, 1, 2, 3));
    pending.push_back(mk(OP_SOLVE, 0, 0, 0));
    pending.push_back(mk(OP_QUERY, 1, 0, 0));
    pending.push_back(mk(OP_QUERY, 2, 0, 0));
    pending.push_back(mk(OP_QUERY, 1023, 0, 0));
    drain();

    write_node_count(600);
    pending.push_back(mk(OP_CLEAR, 0, 0, 0));
    for (int i = 0; i < NUM_EDGES / 2 + 1; i++) begin
      pending.push_back(mk(OP_EDGE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 65535)));
      if (pending.size() > 16) wait (pending.size() < 8);
    end
    pending.push_back(mk(OP_QUERY, 0, 0, 0));
    pending.push_back(mk(OP_CLEAR, 0, 0, 0));
    pending.push_back(mk(OP_QUERY, 0, 0, 0));
    drain();

    idle_on = 1'b1;
    hold_req = 1'b1;
    random_phase(130);
    drain();
    write_node_count(NODE_W'($urandom_range(2, 60)));
    random_phase(120);
    drain();
    write_node_count(NODE_LAST);
    random_phase(120);
    drain();
    idle_on = 1'b0;
    write_node_count(NODE_W'($urandom_range(1, 1022)));
    random_phase(130);
    drain();

    $display("covered %0d transactions, %0d solves and %0d checked query results",
             n_txns, n_solves, n_queries);
    if (errors == 0) begin
      $display("multi_source_shortest_path_tb: clean");
    end else begin
      $display("multi_source_shortest_path_tb: errors");
    end
    $finish;
  end
endmodule
